FILE: hdl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Types, operation codes and word arithmetic for the min-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

    // Operation codes; the unused code behaves as a peek
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam int WORD_W = 34;

    localparam logic signed [31:0] INT_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] EMPTY_TOP = -32'sd1;

    typedef logic signed [WORD_W-1:0] word_t;

    // Input transfer
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } cmd_t;

    // Result transfer
    typedef struct packed {
        logic signed [31:0] top_value;
        logic signed [31:0] min_value;
        logic               is_empty;
        logic               overflow;
        logic               underflow;
    } rsp_t;

    // Sign-extend a 32-bit value to a stored word
    function automatic word_t sext_word(input logic signed [31:0] v);
        sext_word = {{(WORD_W-32){v[31]}}, v};
    endfunction

    // Encoded word 2*value - old minimum
    function automatic word_t encode_word(input logic signed [31:0] v,
                                          input logic signed [31:0] m);
        word_t twice;
        twice = {v[31], v, 1'b0};
        encode_word = twice - sext_word(m);
    endfunction

    // Old minimum 2*minimum - word, modulo 2^32
    function automatic logic signed [31:0] restore_min(input logic signed [31:0] m,
                                                       input word_t w);
        restore_min = {m[30:0], 1'b0} - w[31:0];
    endfunction

    // Top element seen by the user
    function automatic logic signed [31:0] decode_top(input logic empty,
                                                      input word_t w,
                                                      input logic signed [31:0] m);
        if (empty)
            decode_top = EMPTY_TOP;
        else if (w < sext_word(m))
            decode_top = m;
        else
            decode_top = w[31:0];
    endfunction

endpackage

FILE: hdl/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mts_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

FILE: hdl/min_tracking_stack_encoded.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_encoded
// Bounded stack of signed 32-bit values reporting its minimum on every result.
// ----------------------------------------------------------------------------
// Channel   Ports             Handshake
// command   start, cmd        transfer when start high and busy low
// result    done, result      one-cycle strobe, always taken
//
// Push, peek, a rejected push or pop, and a pop that empties the stack return
// their result in the cycle after the transfer. A pop that leaves one or more
// entries first passes through the reload state: the new top word is fetched
// through the entry RAM's registered read port, and busy is high in that state.
// Reset clears the fill count and sets the minimum to the largest signed value;
// RAM contents stay undefined until written. The receiver cannot stall.
// ----------------------------------------------------------------------------
module min_tracking_stack_encoded
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output rsp_t result
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_RELOAD = 1'b1;

    logic               state_reg,    state_next;
    logic [CW-1:0]      fill_reg,     fill_next;
    logic signed [31:0] min_reg,      min_next;
    word_t              top_word_reg, top_word_next;
    logic               done_reg,     done_next;
    rsp_t               result_reg,   result_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    word_t         ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    word_t         ram_rdata;

    logic accept;
    logic is_full;
    logic is_zero;

    assign accept  = start && (state_reg == ST_IDLE);
    assign is_full = (fill_reg == CW'(STACK_DEPTH));
    assign is_zero = (fill_reg == '0);

    // Entry store
    mts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Operation sequencing and result assembly
    always_comb
    begin
        logic  ovf;
        logic  unf;
        logic  hold;
        ovf           = 1'b0;
        unf           = 1'b0;
        hold          = 1'b0;
        state_next    = state_reg;
        fill_next     = fill_reg;
        min_next      = min_reg;
        top_word_next = top_word_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        ram_we        = 1'b0;
        ram_waddr     = fill_reg[AW-1:0];
        ram_wdata     = top_word_reg;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.op)
                        OP_PUSH:
                        begin
                            if (is_full)
                                ovf = 1'b1;
                            else
                            begin
                                if (is_zero || (cmd.value <= min_reg))
                                begin
                                    min_next      = cmd.value;
                                    top_word_next = is_zero ? sext_word(cmd.value)
                                                            : encode_word(cmd.value, min_reg);
                                end
                                else
                                    top_word_next = sext_word(cmd.value);
                                ram_we    = 1'b1;
                                ram_wdata = top_word_next;
                                fill_next = fill_reg + CW'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (is_zero)
                                unf = 1'b1;
                            else
                            begin
                                if (top_word_reg < sext_word(min_reg))
                                    min_next = restore_min(min_reg, top_word_reg);
                                fill_next = fill_reg - CW'(1);
                                // New top lives in the RAM: fetch it first
                                if (fill_reg != CW'(1))
                                begin
                                    hold       = 1'b1;
                                    ram_re     = 1'b1;
                                    ram_raddr  = AW'(fill_reg - CW'(2));
                                    state_next = ST_RELOAD;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (!hold)
                    begin
                        done_next             = 1'b1;
                        result_next.top_value = decode_top(fill_next == '0,
                                                           top_word_next, min_next);
                        result_next.min_value = min_next;
                        result_next.is_empty  = (fill_next == '0);
                        result_next.overflow  = ovf;
                        result_next.underflow = unf;
                    end
                end
            end
            ST_RELOAD:
            begin
                top_word_next         = ram_rdata;
                done_next             = 1'b1;
                result_next.top_value = decode_top(1'b0, ram_rdata, min_reg);
                result_next.min_value = min_reg;
                result_next.is_empty  = 1'b0;
                result_next.overflow  = 1'b0;
                result_next.underflow = 1'b0;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            min_reg   <= INT_MAX;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            min_reg   <= min_next;
            done_reg  <= done_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        top_word_reg <= top_word_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg == ST_RELOAD);
    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(STACK_DEPTH))
        else $error("fill count beyond stack depth");

    a_reload_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> ($past(start) && $past(cmd.op) == OP_POP && !is_zero)
                 || !$past(rst_n))
        else $error("reload without a pop");

    a_reload_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("reload did not deliver a result");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.is_empty == is_zero)
        else $error("empty flag disagrees with fill count");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.overflow && result.underflow))
        else $error("overflow and underflow together");

endmodule
